>>> hdl/hsfc_pkg.sv
// Package with shared types and constants for the binary32/binary16 converter.
`default_nettype none
package hsfc_pkg;
    localparam int unsigned SINGLE_W = 32;
    localparam int unsigned HALF_W   = 16;
    localparam logic FUNC_NARROW = 1'b0;
    localparam logic FUNC_WIDEN  = 1'b1;

    typedef struct packed {
        logic                func;
        logic [SINGLE_W-1:0] single_bits;
        logic [HALF_W-1:0]   half_bits;
    } t_in_beat;

    typedef struct packed {
        logic [SINGLE_W-1:0] converted_bits;
    } t_out_beat;

    // Narrowing paths: a finished special value, a subnormal, or a normal.
    typedef enum logic [1:0] {
        NC_FIXED = 2'd0,
        NC_SUB   = 2'd1,
        NC_NORM  = 2'd2
    } t_nclass;
endpackage
`default_nettype wire

>>> hdl/hsfc_if.sv
// Valid/ready channel interfaces for the converter.
`default_nettype none
interface hsfc_in_if import hsfc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hsfc_out_if import hsfc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/half_single_float_conversion_core.sv
// Converter between binary32 and binary16 bit patterns.
// Usage: operands arrive on i_in (func, single_bits, half_bits) and results leave
// on o_out (converted_bits). func 0 narrows binary32 to binary16 (result in the
// low 16 bits), func 1 widens binary16 to binary32.
// The block is a three-stage pipeline: stage 1 registers the operand with its
// leading-one count and subnormal shift, stage 2 does the mantissa shifts and
// the rounding add, stage 3 applies the round-up carry, saturates and packs.
// A beat accepted into stage 1 moves through the stage 2 register into the
// output register, from which its result is taken on o_out.
// One beat can be accepted in every cycle unless a stall on o_out has filled every stage.
// A stage advances when it is empty or the stage after it advances, so a
// stall on o_out holds every occupied stage and fills the empty ones before
// the input ready drops. Nothing is lost or repeated.
// A synchronous active-low reset clears all valid bits; data registers keep
// whatever they held.
`default_nettype none
module half_single_float_conversion_core import hsfc_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    hsfc_in_if.sink   i_in,
    hsfc_out_if.source o_out
);
    // Stage 1 registers
    logic        r_v1, r_func1, r_sign1;
    logic [7:0]  r_ex1;
    logic [22:0] r_man1;
    logic [4:0]  r_hex1;
    logic [9:0]  r_hman1;
    logic [3:0]  r_lz1;
    logic [4:0]  r_sh1;
    // Stage 2 registers
    logic        r_v2, r_func2, r_sign2;
    t_nclass     r_ncls2;
    logic [15:0] r_nfix2;
    logic [10:0] r_sub2;
    logic        r_rnd2, r_carry2;
    logic [9:0]  r_rmt2;
    logic [7:0]  r_hex2;
    logic [31:0] r_wide2;
    // Stage 3
    logic        r_v3, r_sign3;
    logic [31:0] r_res3;

    logic adv3, adv2, adv1;
    assign adv3 = !r_v3 || o_out.ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign i_in.ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in.valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // Stage 1: leading-one search over the half mantissa and the subnormal shift.
    logic [3:0] in_lz;
    logic [4:0] in_sh;
    always_comb begin
        in_lz = 4'd0;
        for (int i = 0; i < 10; i++)
            if (i_in.data.half_bits[i]) in_lz = 4'(9 - i);
        in_sh = 5'(8'd113 - i_in.data.single_bits[30:23]);
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_func1 <= i_in.data.func;
            r_sign1 <= (i_in.data.func == FUNC_WIDEN) ? i_in.data.half_bits[15]
                                                       : i_in.data.single_bits[31];
            r_ex1   <= i_in.data.single_bits[30:23];
            r_man1  <= i_in.data.single_bits[22:0];
            r_hex1  <= i_in.data.half_bits[14:10];
            r_hman1 <= i_in.data.half_bits[9:0];
            r_lz1   <= in_lz;
            r_sh1   <= in_sh;
        end
    end

    // Stage 2, narrowing: classify, shift into the subnormal field, add the round bit.
    t_nclass     ncls;
    logic [15:0] nfix;
    logic [23:0] full_man;
    logic [10:0] sub_v;
    logic        guard, sticky, rnd;
    logic [23:0] rm;
    logic [7:0]  hex;
    logic [23:0] smask;
    always_comb begin
        full_man = {1'b1, r_man1};
        sub_v    = 11'(full_man >> (r_sh1 + 5'd13));
        guard    = full_man[r_sh1 + 5'd12];
        smask    = (24'd1 << (r_sh1 + 5'd12)) - 24'd1;
        sticky   = |(full_man & smask);
        rnd      = guard && (sub_v[0] || sticky);
        rm       = {1'b0, r_man1} + 24'h001000;
        hex      = r_ex1 - 8'd112;
        ncls     = NC_FIXED;
        nfix     = {r_sign1, 15'd0};
        if (r_ex1 == 8'hFF) begin
            if (r_man1 != 23'd0)
                nfix = {r_sign1, 5'h1F,
                        (r_man1[22:13] == 10'd0) ? 10'd1 : r_man1[22:13]};
            else
                nfix = {r_sign1, 5'h1F, 10'd0};
        end else if (r_ex1 < 8'd103) begin
            nfix = {r_sign1, 15'd0};
        end else if (r_ex1 < 8'd113) begin
            ncls = NC_SUB;
        end else begin
            ncls = NC_NORM;
        end
    end

    // Stage 2, widening: normalize subnormals and drop the leading one.
    logic [10:0] nman;
    logic [31:0] widen_res;
    always_comb begin
        nman = {1'b0, r_hman1} << (r_lz1 + 4'd1);
        if (r_hex1 == 5'd0) begin
            if (r_hman1 == 10'd0) widen_res = {r_sign1, 31'd0};
            else widen_res = {r_sign1, 8'(8'd112 - {4'd0, r_lz1}), nman[9:0], 13'd0};
        end else if (r_hex1 == 5'h1F) begin
            if (r_hman1 == 10'd0) widen_res = {r_sign1, 8'hFF, 23'd0};
            else widen_res = {r_sign1, 8'hFF, 1'b1, r_hman1[8:0], 13'd0};
        end else begin
            widen_res = {r_sign1, 8'({3'd0, r_hex1} + 8'd112), r_hman1, 13'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_func2  <= r_func1;
            r_sign2  <= r_sign1;
            r_ncls2  <= ncls;
            r_nfix2  <= nfix;
            r_sub2   <= sub_v;
            r_rnd2   <= rnd;
            r_carry2 <= rm[23];
            r_rmt2   <= rm[22:13];
            r_hex2   <= hex;
            r_wide2  <= widen_res;
        end
    end

    // Stage 3: round-up carry, exponent bump and saturation to infinity.
    logic [15:0] narrow_res;
    logic [10:0] sub_r;
    logic [7:0]  hex_r;
    logic [9:0]  rman;
    always_comb begin
        sub_r      = r_sub2 + {10'd0, r_rnd2};
        hex_r      = r_hex2 + {7'd0, r_carry2};
        rman       = r_carry2 ? 10'd0 : r_rmt2;
        narrow_res = r_nfix2;
        case (r_ncls2)
            NC_SUB: begin
                narrow_res = {r_sign2, 4'd0, sub_r};
            end
            NC_NORM: begin
                if (hex_r >= 8'h1F) narrow_res = {r_sign2, 5'h1F, 10'd0};
                else narrow_res = {r_sign2, hex_r[4:0], rman};
            end
            default: begin
                narrow_res = r_nfix2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_sign3 <= r_sign2;
            r_res3  <= (r_func2 == FUNC_WIDEN) ? r_wide2 : {16'd0, narrow_res};
        end
    end

    assign o_out.valid = r_v3;
    assign o_out.data.converted_bits = r_res3;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !o_out.ready) |=> (r_v3 && $stable(r_res3)))
        else $error("stalled result changed");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_in.ready) |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with an empty stage");
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_res3[31:16] != 16'd0) |-> r_res3[31] == r_sign3)
        else $error("widened sign lost");
`endif
endmodule
`default_nettype wire
